// ===== rtl/bmt_pkg.sv =====
// Shared constants, types and beat layout for the band matrix transform.
package bmt_pkg;

  // Geometry and number formats
  localparam int MAX_BANDS      = 6;
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 12;
  localparam int COEF_BITS      = 16;
  localparam int IDX_W          = 6;
  localparam int ACT_W          = 3;
  localparam int STORE_DEPTH    = MAX_BANDS * MAX_BANDS;

  // Band count and cell select widths
  localparam int BAND_W = $clog2(MAX_BANDS + 1);
  localparam int SEL_W  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;

  // Datapath widths: one product, and the sum of all products of a row
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + $clog2(MAX_BANDS) + 1;

  // Stream widths
  localparam int IN_DATA_W  = IDX_W + COEF_BITS + MAX_BANDS * SAMPLE_BITS;
  localparam int S_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = MAX_BANDS * SAMPLE_BITS;
  localparam int M_TDATA_W  = ((OUT_DATA_W + 7) / 8) * 8;

  // Register port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_ACTIVE_BANDS = '0;
  localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(6);

  // Item kind carried in tuser
  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_PIXEL = 1'b1
  } mode_e;

  // One item as it travels down the row of cells
  typedef struct packed {
    mode_e                                mode;
    logic [IDX_W-1:0]                     idx;
    logic [COEF_BITS-1:0]                 value;
    logic [MAX_BANDS-1:0][SAMPLE_BITS-1:0] band;
    logic [MAX_BANDS-1:0][ACC_W-1:0]      acc;
  } beat_t;

  // Controls broadcast to every cell
  typedef struct packed {
    logic              en;
    logic [BAND_W-1:0] n;
  } ctrl_t;

endpackage

// ===== rtl/bmt_cell.sv =====
// One cell of the row: holds one coefficient column, multiplies its band and adds to the sums.
module bmt_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bmt_pkg::ctrl_t               ctrl_i,
  input  logic [bmt_pkg::SEL_W-1:0]    cell_id_i,
  input  logic                         vld_i,
  input  bmt_pkg::beat_t               beat_i,
  output logic                         vld_o,
  output bmt_pkg::beat_t               beat_o
);
  import bmt_pkg::*;

  logic [MAX_BANDS-1:0][COEF_BITS-1:0] coef_q, coef_d;
  logic [MAX_BANDS-1:0][PROD_W-1:0]    prod_q, prod_d;
  logic [MAX_BANDS-1:0][ACC_W-1:0]     acc_d;
  logic [SAMPLE_BITS-1:0]              band_sel;
  logic                                mid_vld_q, mid_vld_d;
  beat_t                               mid_q;
  logic                                out_vld_q, out_vld_d;
  beat_t                               out_q, out_d;
  logic                                use_band;

  assign band_sel = beat_i.band[cell_id_i];
  assign use_band = BAND_W'(cell_id_i) < ctrl_i.n;

  // Coefficient column: a passing load beat writes the entry of its row
  always_comb begin
    coef_d = coef_q;
    for (int j = 0; j < MAX_BANDS; j++) begin
      if (ctrl_i.en && vld_i && (beat_i.mode == MODE_LOAD) &&
          (int'(beat_i.idx) == j * MAX_BANDS + int'(cell_id_i))) begin
        coef_d[j] = beat_i.value;
      end
    end
  end

  // Stage A: one product per output row
  always_comb begin
    for (int j = 0; j < MAX_BANDS; j++) begin
      prod_d[j] = $signed({{SAMPLE_BITS{coef_q[j][COEF_BITS-1]}}, coef_q[j]}) *
                  $signed({{COEF_BITS{band_sel[SAMPLE_BITS-1]}}, band_sel});
    end
  end

  assign mid_vld_d = ctrl_i.en ? vld_i : mid_vld_q;

  // Stage B: add products to the running row sums if this cell's band is active
  always_comb begin
    for (int j = 0; j < MAX_BANDS; j++) begin
      acc_d[j] = use_band ?
                 mid_q.acc[j] + {{(ACC_W-PROD_W){prod_q[j][PROD_W-1]}}, prod_q[j]} :
                 mid_q.acc[j];
    end
    out_d     = mid_q;
    out_d.acc = acc_d;
  end

  assign out_vld_d = ctrl_i.en ? mid_vld_q : out_vld_q;

  // Control and coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q    <= '0;
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      coef_q    <= coef_d;
      mid_vld_q <= mid_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= prod_d;
      mid_q  <= beat_i;
      out_q  <= out_d;
    end
  end

  assign vld_o  = out_vld_q;
  assign beat_o = out_q;

endmodule

// ===== rtl/bmt_round.sv =====
// Rounds the row sums to samples, saturates them and masks inactive bands.
module bmt_round (
  input  logic [bmt_pkg::BAND_W-1:0]                                n_i,
  input  logic [bmt_pkg::MAX_BANDS-1:0][bmt_pkg::ACC_W-1:0]         acc_i,
  output logic [bmt_pkg::MAX_BANDS-1:0][bmt_pkg::SAMPLE_BITS-1:0]   band_o,
  output logic                                                      sat_o
);
  import bmt_pkg::*;

  localparam logic signed [ACC_W-1:0] HI   = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] LO   = -HI - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));

  // Round half up, then clip each active row
  always_comb begin
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] shf;
    sat_o = 1'b0;
    for (int j = 0; j < MAX_BANDS; j++) begin
      rnd = $signed(acc_i[j]) + HALF;
      shf = rnd >>> COEF_FRAC_BITS;
      if (BAND_W'(j) >= n_i) begin
        band_o[j] = '0;
      end else if (shf > HI) begin
        band_o[j] = HI[SAMPLE_BITS-1:0];
        sat_o     = 1'b1;
      end else if (shf < LO) begin
        band_o[j] = LO[SAMPLE_BITS-1:0];
        sat_o     = 1'b1;
      end else begin
        band_o[j] = shf[SAMPLE_BITS-1:0];
      end
    end
  end

endmodule

// ===== rtl/band_matrix_transform_top.sv =====
// Top level of the band matrix transform: stream ports, register port, row of cells, output register.
//
// Use: each input beat on s_axis is either a coefficient load (tuser = 0) or a
// pixel (tuser = 1). A load writes coefficient coef_index = row*6 + column in
// Q4.12 and produces no output beat. A pixel carries all six bands and produces
// one output beat with six rounded, saturated bands in tdata and the saturation
// flag in tuser. Bands at or above active_bands read as zero.
// The work flows through a row of six cells, one per input band, each two
// registers deep (product, then sum), followed by the output register. One
// beat is accepted every cycle while m_axis does not stall; loads and pixels
// may be mixed freely and a load reaches each cell behind every earlier pixel,
// so ordering holds.
// When m_axis stalls with a beat held, the whole row holds and s_axis_tready
// drops in the same cycle; no beat is dropped.
// Reset clears all coefficients to zero, empties the row and sets
// active_bands to 6. The register port takes writes at any time but should
// only be written with the row empty.
module band_matrix_transform_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // coef_index[5:0], coef_value[21:6], band_in_0..5 16 bits each from bit 22, pad
  input  logic [bmt_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // mode
  input  logic                              s_axis_tuser,
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // band_out_0..5, 16 bits each from bit 0
  output logic [bmt_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // saturated
  output logic                              m_axis_tuser,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bmt_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [bmt_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bmt_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import bmt_pkg::*;

  logic [ACT_W-1:0]                      active_q, active_d;
  logic [APB_ADDR_W-3:0]                 reg_sel;
  logic                                  reg_wr;
  ctrl_t                                 ctrl;
  logic [MAX_BANDS:0]                    chain_vld;
  beat_t                                 chain_beat [MAX_BANDS+1];
  logic [MAX_BANDS-1:0][SAMPLE_BITS-1:0] rnd_band;
  logic                                  rnd_sat;
  logic                                  m_vld_q, m_vld_d;
  logic [M_TDATA_W-1:0]                  m_data_q;
  logic                                  m_sat_q;

  // Register port
  assign pready   = 1'b1;
  assign reg_sel  = paddr[APB_ADDR_W-1:2];
  assign reg_wr   = psel && penable && pwrite && pready && (reg_sel == REG_ACTIVE_BANDS);
  assign active_d = reg_wr ? pwdata[ACT_W-1:0] : active_q;
  assign prdata   = (reg_sel == REG_ACTIVE_BANDS) ? APB_DATA_W'(active_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RESET;
    end else begin
      active_q <= active_d;
    end
  end

  // Row control: advance unless a held output beat is stalled
  assign ctrl.en = !m_vld_q || m_axis_tready;
  assign ctrl.n  = (BAND_W'(active_q) > BAND_W'(MAX_BANDS)) ? BAND_W'(MAX_BANDS)
                                                             : BAND_W'(active_q);
  assign s_axis_tready = ctrl.en;

  // Unpack the input beat into the head of the row
  always_comb begin
    chain_beat[0].mode  = mode_e'(s_axis_tuser);
    chain_beat[0].idx   = s_axis_tdata[IDX_W-1:0];
    chain_beat[0].value = s_axis_tdata[IDX_W +: COEF_BITS];
    chain_beat[0].band  = s_axis_tdata[IDX_W+COEF_BITS +: MAX_BANDS*SAMPLE_BITS];
    chain_beat[0].acc   = '0;
  end
  assign chain_vld[0] = s_axis_tvalid;

  // Row of cells, one per input band
  for (genvar k = 0; k < MAX_BANDS; k++) begin : g_cell
    bmt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .cell_id_i (SEL_W'(k)),
      .vld_i     (chain_vld[k]),
      .beat_i    (chain_beat[k]),
      .vld_o     (chain_vld[k+1]),
      .beat_o    (chain_beat[k+1])
    );
  end

  // Rounding and saturation of the finished sums
  bmt_round u_round (
    .n_i    (ctrl.n),
    .acc_i  (chain_beat[MAX_BANDS].acc),
    .band_o (rnd_band),
    .sat_o  (rnd_sat)
  );

  // Output register: only pixel beats pass to the output
  assign m_vld_d = ctrl.en ? (chain_vld[MAX_BANDS] && (chain_beat[MAX_BANDS].mode == MODE_PIXEL))
                           : m_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en) begin
      m_data_q <= M_TDATA_W'(rnd_band);
      m_sat_q  <= rnd_sat;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_sat_q;

  // A load leaving the row never becomes an output beat
  a_load_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.en && chain_vld[MAX_BANDS] && (chain_beat[MAX_BANDS].mode == MODE_LOAD)
    |=> !m_axis_tvalid)
    else $error("load beat produced an output beat");

  // A stalled row keeps every occupied slot
  a_row_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl.en |=> $stable(chain_vld[MAX_BANDS:1]))
    else $error("row moved while stalled");

  // With no active band nothing can saturate
  a_no_sat_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.en && (ctrl.n == '0) |=> !m_axis_tuser)
    else $error("saturation flagged with no active band");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for band_matrix_transform_top: streamed loads and pixels, APB setup.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bmt_pkg::*;

  // One input beat: fields in tdata order (band high, index low), kind in tuser
  typedef struct packed {
    mode_e                                 mode;
    logic [MAX_BANDS-1:0][SAMPLE_BITS-1:0] band;
    logic [COEF_BITS-1:0]                  value;
    logic [IDX_W-1:0]                      idx;
  } item_t;

  // One output beat as predicted
  typedef struct packed {
    logic                                  sat;
    logic [MAX_BANDS-1:0][SAMPLE_BITS-1:0] band;
  } pix_result_t;

  localparam longint SAMPLE_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_LO = -SAMPLE_HI - 1;
  localparam logic [APB_ADDR_W-1:0] BANDS_ADDR = {REG_ACTIVE_BANDS, 2'b00};
  localparam int ROW_LATENCY = 12;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Local copy of the block's state
  logic signed [COEF_BITS-1:0] coef_mem [STORE_DEPTH];
  logic [ACT_W-1:0]            act_bands = ACTIVE_RESET;

  item_t       pending[$];
  item_t       cur_beat;
  pix_result_t pix_expect[$];
  int          gap_left = 0;
  int          stall_left = 0;
  int          pushed_cnt = 0;
  int          taken_cnt = 0;
  int          err_cnt = 0;
  int          pix_cnt = 0;
  int          load_cnt = 0;
  int          clip_cnt = 0;
  bit          quiet = 1'b0;

  band_matrix_transform_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5ns clk_i = ~clk_i;

  // Matrix-vector product with rounding and clipping over the active bands
  function automatic pix_result_t mix_bands(input item_t it);
    pix_result_t res;
    int          n;
    longint      acc;
    longint      r;
    res = '0;
    n = (act_bands > MAX_BANDS) ? MAX_BANDS : int'(act_bands);
    for (int j = 0; j < n; j++) begin
      acc = 0;
      for (int i = 0; i < n; i++) begin
        acc += longint'(coef_mem[j*MAX_BANDS + i]) * longint'($signed(it.band[i]));
      end
      // round half up, then floor
      r = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      if (r > SAMPLE_HI) begin
        r = SAMPLE_HI;
        res.sat = 1'b1;
      end else if (r < SAMPLE_LO) begin
        r = SAMPLE_LO;
        res.sat = 1'b1;
      end
      res.band[j] = r[SAMPLE_BITS-1:0];
    end
    return res;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int next_gap();
    int pick;
    if (quiet) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Coefficients and samples: small, full range, near unity, or extreme
  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 8192)) - 16'd4096;
      1: return 16'($urandom);
      2: return 16'($urandom_range(2048, 6144)) ^ {16{$urandom_range(0, 1) == 1}};
      default: begin
        case ($urandom_range(0, 4))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return 16'h1000;
          default: return 16'hffff;
        endcase
      end
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.band = {$urandom, $urandom, $urandom};
    it.value = 16'($urandom);
    it.idx = 6'($urandom);
    if ($urandom_range(0, 99) < 40) begin
      it.mode = MODE_LOAD;
      it.idx = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(36, 63))
                                           : 6'($urandom_range(0, 35));
      it.value = rand_word();
    end else begin
      it.mode = MODE_PIXEL;
      for (int i = 0; i < MAX_BANDS; i++) it.band[i] = rand_word();
    end
    return it;
  endfunction

  function automatic item_t load_item(input logic [IDX_W-1:0] idx, input logic [15:0] value);
    item_t it;
    it = '0;
    it.mode = MODE_LOAD;
    it.idx = idx;
    it.value = value;
    return it;
  endfunction

  function automatic item_t pixel_item(input logic [MAX_BANDS-1:0][SAMPLE_BITS-1:0] b);
    item_t it;
    it = '0;
    it.mode = MODE_PIXEL;
    it.band = b;
    return it;
  endfunction

  task automatic queue_item(input item_t it);
    pending.push_back(it);
    pushed_cnt++;
  endtask

  // Wait until every beat is taken and every result is back, then let loads drain
  task automatic drain_row();
    while (taken_cnt != pushed_cnt || pix_expect.size() != 0) @(posedge clk_i);
    repeat (ROW_LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read(input logic [APB_ADDR_W-1:0] addr, output logic [APB_DATA_W-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_bands_reg(input logic [ACT_W-1:0] want);
    logic [APB_DATA_W-1:0] rd;
    apb_read(BANDS_ADDR, rd);
    if (rd !== APB_DATA_W'(want)) begin
      $display("%0t: active_bands read expected %0d actual %0d", $time, want, rd);
      err_cnt++;
    end
  endtask

  task automatic program_bands(input logic [ACT_W-1:0] val);
    apb_write(BANDS_ADDR, APB_DATA_W'(val));
    check_bands_reg(val);
    act_bands = val;
  endtask

  // Driver: feeds pending beats with random gaps, predicts each accepted beat
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left <= 0;
      foreach (coef_mem[k]) coef_mem[k] = '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        if (cur_beat.mode == MODE_PIXEL) begin
          pix_expect.push_back(mix_bands(cur_beat));
          pix_cnt++;
        end else begin
          load_cnt++;
          // out-of-range index leaves the store alone
          if (cur_beat.idx < STORE_DEPTH) coef_mem[cur_beat.idx] = cur_beat.value;
        end
        taken_cnt++;
      end
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending.size() != 0) begin
        cur_beat = pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= S_TDATA_W'({cur_beat.band, cur_beat.value, cur_beat.idx});
        s_axis_tuser <= cur_beat.mode;
        gap_left <= next_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure and field-by-field check of each output beat
  always @(posedge clk_i) begin
    pix_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left <= next_gap();
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pix_expect.size() == 0) begin
          $display("%0t: output beat with nothing expected, actual tdata %h tuser %b",
                   $time, m_axis_tdata, m_axis_tuser);
          err_cnt++;
        end else begin
          want = pix_expect.pop_front();
          if (want.sat) clip_cnt++;
          for (int j = 0; j < MAX_BANDS; j++) begin
            if (m_axis_tdata[j*SAMPLE_BITS +: SAMPLE_BITS] !== want.band[j]) begin
              $display("%0t: band_out_%0d expected %0d actual %0d", $time, j,
                       $signed(want.band[j]),
                       $signed(m_axis_tdata[j*SAMPLE_BITS +: SAMPLE_BITS]));
              err_cnt++;
            end
          end
          if (m_axis_tuser !== want.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, want.sat, m_axis_tuser);
            err_cnt++;
          end
        end
      end
    end
  end

  // Main sequence
  initial begin
    static logic [ACT_W-1:0] phase_bands [10] = '{3'd6, 3'd1, 3'd0, 3'd7, 3'd2,
                                                  3'd3, 3'd4, 3'd5, 3'd6, 3'd1};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_bands_reg(ACTIVE_RESET);

    // Directed: cleared store, identity, ignored loads, clipping both ways, rounding ties
    queue_item(pixel_item({6{16'h7fff}}));
    for (int d = 0; d < MAX_BANDS; d++) queue_item(load_item(IDX_W'(d*(MAX_BANDS+1)), 16'h1000));
    queue_item(pixel_item({16'd12345, 16'hffff, 16'h0001, 16'h0000, 16'h8000, 16'h7fff}));
    queue_item(load_item(6'd36, 16'h7fff));
    queue_item(load_item(6'd63, 16'h8000));
    queue_item(pixel_item({16'd12345, 16'hffff, 16'h0001, 16'h0000, 16'h8000, 16'h7fff}));
    queue_item(load_item(6'd0, 16'h7fff));
    queue_item(load_item(6'd1, 16'h7fff));
    queue_item(load_item(6'd6, 16'h8000));
    queue_item(load_item(6'd7, 16'h8000));
    queue_item(pixel_item({6{16'h7fff}}));
    queue_item(pixel_item({6{16'h8000}}));
    queue_item(load_item(6'd0, 16'h0800));
    queue_item(load_item(6'd1, 16'h0000));
    queue_item(pixel_item({16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0001}));
    queue_item(pixel_item({16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hffff}));

    // Random phases over band counts, extremes and out-of-range values included
    for (int p = 0; p < 10; p++) begin
      drain_row();
      program_bands(phase_bands[p]);
      quiet = (p == 3) || (p == 7);
      for (int k = 0; k < 68; k++) queue_item(rand_item());
    end
    drain_row();

    if (pix_expect.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pix_expect.size());
      err_cnt++;
    end
    $display("summary: %0d pixels checked (%0d clipped), %0d coefficient loads,",
             pix_cnt, clip_cnt, load_cnt);
    $display("summary: active band counts 0 through 7 with gaps and back-pressure");
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("%0t: timeout", $time);
    $display("tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bmt_pkg.sv
rtl/bmt_cell.sv
rtl/bmt_round.sv
rtl/band_matrix_transform_top.sv
test/tb.sv
